>>> rtl/calendar_date_add_days_assert.svh
// Assertion macros for the calendar date adder.
// Included by the top level only; needs no package.
`ifndef CALENDAR_DATE_ADD_DAYS_ASSERT_SVH
`define CALENDAR_DATE_ADD_DAYS_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CDAD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("calendar date adder: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CDAD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("calendar date adder: next-cycle check failed");

`endif

>>> rtl/cdad_pkg.sv
// Package for the calendar date adder: field types, calendar constants,
// sequencer states and the control and status structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cdad_pkg;

   typedef logic [13:0] year_type;
   typedef logic [3:0]  month_type;
   typedef logic [4:0]  mday_type;
   typedef logic [15:0] count_type;
   typedef logic [16:0] acc_type;
   typedef logic [4:0]  mod25_type;
   typedef logic [26:0] prod_type;

   localparam year_type  MAX_YEAR     = 14'd9999;
   localparam count_type MAX_ADD_DAYS = 16'd65535;

   localparam month_type MONTH_JAN = 4'd1;
   localparam month_type MONTH_FEB = 4'd2;
   localparam month_type MONTH_APR = 4'd4;
   localparam month_type MONTH_JUN = 4'd6;
   localparam month_type MONTH_SEP = 4'd9;
   localparam month_type MONTH_NOV = 4'd11;
   localparam month_type MONTH_DEC = 4'd12;

   localparam mday_type DAYS_28 = 5'd28;
   localparam mday_type DAYS_29 = 5'd29;
   localparam mday_type DAYS_30 = 5'd30;
   localparam mday_type DAYS_31 = 5'd31;

   // floor(y / 25) = (y * RECIP_25) >> RECIP_SHIFT for every 14-bit y.
   localparam logic [12:0] RECIP_25    = 13'd5243;
   localparam int          RECIP_SHIFT = 17;
   localparam mod25_type   MOD25_LAST  = 5'd24;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_MOD,
      ST_CHECK,
      ST_WALK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic mul_en;
      logic mod_en;
      logic add_en;
      logic step_en;
   } ctl_type;

   typedef struct packed {
      logic date_ok;
      logic fits;
      logic year_ovf;
   } status_type;

endpackage

`default_nettype wire

>>> rtl/calendar_date_add_days.sv
// Top level of the calendar date adder: handshakes, sequencer and flags.
// Depends on cdad_pkg, cdad_dp and calendar_date_add_days_assert.svh.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid, req_ready   year, month, day, days to add
//   rsp_      out        rsp_valid, rsp_ready   year, month, day, two flags
//
// One transfer is in the block at a time; req_ready is high only when idle.
// An item passes the multiply, modulo and check states, then one walk step per
// month carried; the month compare and subtract sets the length of the walk.
// An invalid start date goes from the check state straight to done, with no walk.
// Reset is synchronous and returns the sequencer to idle with no result.
// The result is held in the output registers while rsp_ready is low.
`timescale 1ns / 1ps
`default_nettype none

`include "calendar_date_add_days_assert.svh"

module calendar_date_add_days (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire cdad_pkg::year_type  req_year_in,
   input  wire cdad_pkg::month_type req_month_in,
   input  wire cdad_pkg::mday_type  req_day_in,
   input  wire cdad_pkg::count_type req_days_to_add,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output cdad_pkg::year_type       rsp_year_out,
   output cdad_pkg::month_type      rsp_month_out,
   output cdad_pkg::mday_type       rsp_day_out,
   output logic                     rsp_input_invalid,
   output logic                     rsp_year_overflow
);

   cdad_pkg::state_type  state_ff, state_in;
   logic                 invalid_ff, invalid_in;
   logic                 overflow_ff, overflow_in;
   cdad_pkg::ctl_type    ctl;
   cdad_pkg::status_type status;
   logic                 sat_ok;
   logic                 date_out_ok;

   cdad_dp u_dp (
      .clock     (clock),
      .ctl       (ctl),
      .year_in   (req_year_in),
      .month_in  (req_month_in),
      .day_in    (req_day_in),
      .add_in    (req_days_to_add),
      .year_out  (rsp_year_out),
      .month_out (rsp_month_out),
      .day_out   (rsp_day_out),
      .status    (status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= cdad_pkg::ST_IDLE;
         invalid_ff  <= 1'b0;
         overflow_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         invalid_ff  <= invalid_in;
         overflow_ff <= overflow_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      invalid_in  = invalid_ff;
      overflow_in = overflow_ff;
      ctl         = '0;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      unique case (state_ff)
         cdad_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.load    = 1'b1;
               invalid_in  = 1'b0;
               overflow_in = 1'b0;
               state_in    = cdad_pkg::ST_MUL;
            end
         end
         cdad_pkg::ST_MUL: begin
            ctl.mul_en = 1'b1;
            state_in   = cdad_pkg::ST_MOD;
         end
         cdad_pkg::ST_MOD: begin
            ctl.mod_en = 1'b1;
            state_in   = cdad_pkg::ST_CHECK;
         end
         cdad_pkg::ST_CHECK: begin
            if (status.date_ok) begin
               ctl.add_en = 1'b1;
               state_in   = cdad_pkg::ST_WALK;
            end else begin
               invalid_in = 1'b1;
               state_in   = cdad_pkg::ST_DONE;
            end
         end
         cdad_pkg::ST_WALK: begin
            ctl.step_en = 1'b1;
            if (status.fits) begin
               state_in = cdad_pkg::ST_DONE;
            end else if (status.year_ovf) begin
               overflow_in = 1'b1;
               state_in    = cdad_pkg::ST_DONE;
            end
         end
         cdad_pkg::ST_DONE: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = cdad_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cdad_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_input_invalid = invalid_ff;
   assign rsp_year_overflow = overflow_ff;

   assign sat_ok      = (rsp_year_out == cdad_pkg::MAX_YEAR) &&
                        (rsp_month_out == cdad_pkg::MONTH_DEC) &&
                        (rsp_day_out == cdad_pkg::DAYS_31);
   assign date_out_ok = (rsp_month_out != 4'd0) && (rsp_month_out <= cdad_pkg::MONTH_DEC) &&
                        (rsp_day_out != 5'd0);

   `CDAD_ASSERT_SAME(a_one_item, clock, reset, rsp_valid, !req_ready)
   `CDAD_ASSERT_NEXT(a_no_early_result, clock, reset, req_valid && req_ready, !rsp_valid)
   `CDAD_ASSERT_SAME(a_overflow_saturates, clock, reset, rsp_valid && rsp_year_overflow, sat_ok)
   `CDAD_ASSERT_SAME(a_valid_date_out, clock, reset, rsp_valid && !rsp_input_invalid, date_out_ok)

endmodule

`default_nettype wire

>>> rtl/cdad_mlen.sv
// Month length unit: leap-year test and days in the month.
// Depends on cdad_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cdad_mlen (
   input  wire logic [3:0]          year_lo,
   input  wire cdad_pkg::mod25_type year_mod25,
   input  wire cdad_pkg::month_type month,
   output cdad_pkg::mday_type       length
);

   logic leap;

   // A year is leap when divisible by four, unless it is a century year
   // that is not also divisible by sixteen (that is, by four hundred).
   assign leap = (year_lo[1:0] == 2'b00) &&
                 ((year_mod25 != '0) || (year_lo == 4'b0000));

   always_comb begin
      unique case (month)
         cdad_pkg::MONTH_FEB: begin
            length = leap ? cdad_pkg::DAYS_29 : cdad_pkg::DAYS_28;
         end
         cdad_pkg::MONTH_APR, cdad_pkg::MONTH_JUN,
         cdad_pkg::MONTH_SEP, cdad_pkg::MONTH_NOV: begin
            length = cdad_pkg::DAYS_30;
         end
         default: begin
            length = cdad_pkg::DAYS_31;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/cdad_dp.sv
// Datapath of the date adder: date registers, the year modulo 25 unit and
// the shared compare and subtract that carries one month per step.
// Depends on cdad_pkg and cdad_mlen.
`timescale 1ns / 1ps
`default_nettype none

module cdad_dp (
   input  wire logic                clock,
   input  wire cdad_pkg::ctl_type   ctl,
   input  wire cdad_pkg::year_type  year_in,
   input  wire cdad_pkg::month_type month_in,
   input  wire cdad_pkg::mday_type  day_in,
   input  wire cdad_pkg::count_type add_in,
   output cdad_pkg::year_type       year_out,
   output cdad_pkg::month_type      month_out,
   output cdad_pkg::mday_type       day_out,
   output cdad_pkg::status_type     status
);

   cdad_pkg::year_type  year_ff,  year_next_in;
   cdad_pkg::month_type month_ff, month_next_in;
   cdad_pkg::acc_type   day_ff,   day_next_in;
   cdad_pkg::count_type add_ff,   add_next_in;
   cdad_pkg::prod_type  prod_ff,  prod_in;
   cdad_pkg::mod25_type mod25_ff, mod25_in;

   cdad_pkg::mday_type  len;
   logic [9:0]          quot;
   logic [14:0]         quot25;
   logic [14:0]         rem;
   logic [14:0]         year_inc;
   cdad_pkg::count_type add_sat;

   cdad_mlen u_mlen (
      .year_lo    (year_ff[3:0]),
      .year_mod25 (mod25_ff),
      .month      (month_ff),
      .length     (len)
   );

   assign quot     = prod_ff[26:cdad_pkg::RECIP_SHIFT];
   assign quot25   = {1'b0, quot, 4'b0000} + {2'b00, quot, 3'b000} + {5'b00000, quot};
   assign rem      = {1'b0, year_ff} - quot25;
   assign year_inc = {1'b0, year_ff} + 15'd1;
   assign add_sat  = (add_ff > cdad_pkg::MAX_ADD_DAYS) ? cdad_pkg::MAX_ADD_DAYS : add_ff;

   assign status.fits     = (day_ff <= {12'd0, len});
   assign status.year_ovf = (month_ff == cdad_pkg::MONTH_DEC) &&
                            (year_inc > {1'b0, cdad_pkg::MAX_YEAR});
   assign status.date_ok  = (year_ff != '0) && (year_ff <= cdad_pkg::MAX_YEAR) &&
                            (month_ff != '0) && (month_ff <= cdad_pkg::MONTH_DEC) &&
                            (day_ff != '0) && (day_ff <= {12'd0, len});

   always_comb begin
      year_next_in  = year_ff;
      month_next_in = month_ff;
      day_next_in   = day_ff;
      add_next_in   = add_ff;
      prod_in       = prod_ff;
      mod25_in      = mod25_ff;
      if (ctl.load) begin
         year_next_in  = year_in;
         month_next_in = month_in;
         day_next_in   = {12'd0, day_in};
         add_next_in   = add_in;
      end else if (ctl.mul_en) begin
         prod_in = {13'd0, year_ff} * {14'd0, cdad_pkg::RECIP_25};
      end else if (ctl.mod_en) begin
         mod25_in = rem[4:0];
      end else if (ctl.add_en) begin
         day_next_in = day_ff + {1'b0, add_sat};
      end else if (ctl.step_en && !status.fits) begin
         if (status.year_ovf) begin
            year_next_in  = cdad_pkg::MAX_YEAR;
            month_next_in = cdad_pkg::MONTH_DEC;
            day_next_in   = {12'd0, cdad_pkg::DAYS_31};
         end else begin
            day_next_in = day_ff - {12'd0, len};
            if (month_ff == cdad_pkg::MONTH_DEC) begin
               month_next_in = cdad_pkg::MONTH_JAN;
               year_next_in  = year_inc[13:0];
               mod25_in      = (mod25_ff == cdad_pkg::MOD25_LAST) ? '0 : mod25_ff + 5'd1;
            end else begin
               month_next_in = month_ff + 4'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      year_ff  <= year_next_in;
      month_ff <= month_next_in;
      day_ff   <= day_next_in;
      add_ff   <= add_next_in;
      prod_ff  <= prod_in;
      mod25_ff <= mod25_in;
   end

   assign year_out  = year_ff;
   assign month_out = month_ff;
   assign day_out   = day_ff[4:0];

endmodule

`default_nettype wire
